@@ src/bta_pkg.sv @@
// Shared types and constants of the boundary-tag heap allocator.
// No dependencies; imported by every module of the block but bta_ram.
`timescale 1ns / 1ps
package bta_pkg;

	localparam int ARENA_BYTES_DEF = 4096;
	localparam int TAG_BYTES       = 4;
	localparam int LINK_BYTES      = 8;
	localparam int MIN_REQ         = 2 * (TAG_BYTES + LINK_BYTES);
	localparam int SPLIT_SLACK     = 4 * TAG_BYTES + 2 * LINK_BYTES;
	localparam int LEFT_OFS        = TAG_BYTES;
	localparam int RIGHT_OFS       = TAG_BYTES + LINK_BYTES;
	localparam int REQ_W           = 13;
	localparam int PTR_W           = 12;
	localparam int TAG_W           = 32;

	typedef enum logic [1:0] {
		CMD_INIT  = 2'd0,
		CMD_ALLOC = 2'd1,
		CMD_FREE  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ACC_RD_TAG,
		ACC_RD_LINK,
		ACC_WR_TAG,
		ACC_WR_LINK
	} acc_op_t;

	typedef struct packed {
		logic    valid;
		acc_op_t op;
	} acc_req_t;

	typedef struct packed {
		logic valid;
		logic status;
	} fin_t;

	typedef enum logic [5:0] {
		ST_IDLE,
		ST_I0, ST_I1, ST_I2, ST_I3,
		ST_A_TAG, ST_A_CHK, ST_A_NEXT, ST_A_TEST,
		ST_A_S0, ST_A_S1, ST_A_S2, ST_A_S3, ST_A_UDONE,
		ST_U_TAG, ST_U_LP, ST_U_RP, ST_U_L1, ST_U_W1, ST_U_L2, ST_U_W2,
		ST_U_L3, ST_U_NT, ST_U_WR, ST_U_WB,
		ST_J_RS, ST_J_LT, ST_J_W0, ST_J_W1,
		ST_F_TAG, ST_F_E0, ST_F_E1, ST_F_E2, ST_F_E3,
		ST_F_R0, ST_F_R1, ST_F_W0, ST_F_R2, ST_F_W1, ST_F_W2, ST_F_W3,
		ST_F_T, ST_F_W4, ST_F_W5, ST_F_LT, ST_F_LM, ST_F_CUR, ST_F_NT,
		ST_FIN
	} state_t;

endpackage

@@ src/boundary_tag_heap_allocator.sv @@
// Channel   Dir  Payload                                            Transaction
// s_axis    in   tdata {block_addr, req_size}, tuser command         tvalid & tready
// m_axis    out  tdata result_addr, tuser status                     tvalid & tready
//
// One command at a time; all work goes through a byte-wide arena RAM.
// Tags and links move through the arena one byte per cycle.
// Reset clears the free list; the arena is undefined until an init.
// The result sits in an output register, so a new command is taken while it waits.
// Top level: depends on bta_pkg, bta_ctrl, bta_mem_port, bta_ram.
`timescale 1ns / 1ps
module boundary_tag_heap_allocator import bta_pkg::*; #(
	parameter int ARENA_BYTES = ARENA_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [12:0] req_size, [24:13] block_addr, rest zero
	input  logic [1:0]  s_tuser,  // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [11:0] result_addr, rest zero
	output logic [0:0]  m_tuser   // [0] status
);

	localparam int AW = $clog2(ARENA_BYTES);

	acc_req_t         acc_req;
	logic [AW-1:0]    acc_addr;
	logic [TAG_W-1:0] acc_data;
	logic             acc_done;
	logic [TAG_W-1:0] acc_rdata;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr, ram_raddr;
	logic [7:0]       ram_wdata, ram_rdata;
	fin_t             fin;
	logic [PTR_W-1:0] fin_addr;
	logic             out_free;
	logic             m_tvalid_q;
	logic [PTR_W-1:0] res_q;
	logic             stat_q;

	assign out_free = !m_tvalid_q || m_tready;

	bta_ctrl #(.ARENA_BYTES(ARENA_BYTES)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.command    (s_tuser),
		.req_size   (s_tdata[12:0]),
		.block_addr (s_tdata[24:13]),
		.out_free   (out_free),
		.fin        (fin),
		.result_addr(fin_addr),
		.acc_req    (acc_req),
		.acc_addr   (acc_addr),
		.acc_data   (acc_data),
		.acc_done   (acc_done),
		.acc_rdata  (acc_rdata)
	);

	bta_mem_port #(.ARENA_BYTES(ARENA_BYTES)) u_port (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (acc_req),
		.addr     (acc_addr),
		.wdata    (acc_data),
		.done     (acc_done),
		.rdata    (acc_rdata),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	bta_ram #(.WIDTH(8), .DEPTH(ARENA_BYTES)) u_arena (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fin.valid) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin.valid) begin
			res_q  <= fin_addr;
			stat_q <= fin.status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'd0, res_q};
	assign m_tuser  = stat_q;

endmodule

@@ src/bta_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
module bta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/bta_mem_port.sv @@
// Byte-serial access unit: turns tag and link reads/writes into byte RAM accesses.
// Depends on bta_pkg; drives one bta_ram.
`timescale 1ns / 1ps
module bta_mem_port import bta_pkg::*; #(
	parameter int ARENA_BYTES = ARENA_BYTES_DEF,
	localparam int AW = $clog2(ARENA_BYTES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  acc_req_t         req,
	input  logic [AW-1:0]    addr,
	input  logic [TAG_W-1:0] wdata,
	output logic             done,
	output logic [TAG_W-1:0] rdata,
	output logic             ram_we,
	output logic [AW-1:0]    ram_waddr,
	output logic [7:0]       ram_wdata,
	output logic [AW-1:0]    ram_raddr,
	input  logic [7:0]       ram_rdata
);

	logic             busy_q;
	logic             done_q;
	logic [3:0]       cnt_q;
	acc_op_t          op_q;
	logic [AW-1:0]    base_q;
	logic [TAG_W-1:0] data_q;
	logic [TAG_W-1:0] rdata_q;
	logic [3:0]       nbytes;
	logic             is_wr;
	logic             last;
	logic [1:0]       cap_idx;

	always_comb begin
		unique case (op_q)
			ACC_RD_TAG:  nbytes = 4'(TAG_BYTES);
			ACC_RD_LINK: nbytes = 4'd2; // link values fit in the low two bytes
			ACC_WR_TAG:  nbytes = 4'(TAG_BYTES);
			ACC_WR_LINK: nbytes = 4'(LINK_BYTES);
			default:     nbytes = 4'(TAG_BYTES);
		endcase
	end

	assign is_wr   = (op_q == ACC_WR_TAG) || (op_q == ACC_WR_LINK);
	assign last    = is_wr ? (cnt_q == nbytes - 4'd1) : (cnt_q == nbytes);
	assign cap_idx = 2'(cnt_q - 4'd1);

	assign ram_we    = busy_q && is_wr;
	assign ram_waddr = base_q + AW'(cnt_q);
	assign ram_raddr = base_q + AW'(cnt_q);
	assign ram_wdata = (cnt_q[3:2] == 2'd0) ? data_q[{cnt_q[1:0], 3'b000} +: 8] : 8'd0;

	assign done  = done_q;
	assign rdata = rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 4'd0;
		end else begin
			done_q <= busy_q && last;
			if (req.valid && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'd0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && !busy_q) begin
			op_q    <= req.op;
			base_q  <= addr;
			data_q  <= wdata;
			rdata_q <= '0;
		end else if (busy_q && !is_wr && cnt_q != 4'd0) begin
			// read data arrives in the cycle after its address
			rdata_q[{cap_idx, 3'b000} +: 8] <= ram_rdata;
		end
	end

endmodule

@@ src/bta_ctrl.sv @@
// Command sequencer: init, next-fit allocate and coalescing free over the arena.
// Depends on bta_pkg; issues one tag or link access at a time to bta_mem_port.
`timescale 1ns / 1ps
module bta_ctrl import bta_pkg::*; #(
	parameter int ARENA_BYTES = ARENA_BYTES_DEF,
	localparam int AW = $clog2(ARENA_BYTES)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       command,
	input  logic [REQ_W-1:0] req_size,
	input  logic [PTR_W-1:0] block_addr,
	input  logic             out_free,
	output fin_t             fin,
	output logic [PTR_W-1:0] result_addr,
	output acc_req_t         acc_req,
	output logic [AW-1:0]    acc_addr,
	output logic [TAG_W-1:0] acc_data,
	input  logic             acc_done,
	input  logic [TAG_W-1:0] acc_rdata
);

	typedef logic [AW-1:0] aw_t;
	typedef logic [AW:0]   lim_t;

	localparam aw_t  OFS_L   = aw_t'(LEFT_OFS);
	localparam aw_t  OFS_R   = aw_t'(RIGHT_OFS);
	localparam aw_t  OFS_T   = aw_t'(TAG_BYTES);
	localparam lim_t ARENA_N = lim_t'(ARENA_BYTES);

	state_t           state_q, state_d;
	state_t           uret_q, jret_q;
	logic             issued_q;
	logic             hp_q;
	aw_t              fh_q, start_q, ub_q, lb_q, fb_q, lp_q, rp_q;
	aw_t              urtag_q, frtag_q, nextl_q;
	lim_t             limit_q, steps_q;
	logic [REQ_W-1:0] size_q;
	logic [TAG_W-1:0] sz_q, t_q, rsz_q, nsz_q;
	logic [PTR_W-1:0] res_q;
	logic             stat_q;

	aw_t              link_rd;
	logic [TAG_W-1:0] need_w, slack_w, neg_busy, rest;
	logic             too_small, do_split, rd_pos, below_lim;
	logic [33:0]      cur_end;
	lim_t             init_n;
	logic             init_small;
	logic             walk_fail;
	logic             unl_last;

	assign link_rd   = aw_t'(acc_rdata);
	assign need_w    = 32'(size_q) + 32'(2 * TAG_BYTES);
	assign slack_w   = 32'(size_q) + 32'(SPLIT_SLACK);
	assign neg_busy  = 32'd0 - need_w;
	assign rest      = sz_q - need_w;
	assign too_small = $signed(sz_q) < $signed(need_w);
	assign do_split  = $signed(sz_q) > $signed(slack_w);
	assign rd_pos    = !acc_rdata[TAG_W-1] && (acc_rdata != '0);
	assign cur_end   = 34'({{(34-AW){1'b0}}, fb_q}) + {{2{acc_rdata[TAG_W-1]}}, acc_rdata};
	assign below_lim = $signed(cur_end) < $signed({{(33-AW){1'b0}}, limit_q});
	assign init_n    = ({4'd0, req_size} > 17'(ARENA_BYTES)) ? ARENA_N : lim_t'(req_size);
	assign init_small = init_n < lim_t'(MIN_REQ);
	assign walk_fail = (fh_q == start_q) || (steps_q > ARENA_N);
	assign unl_last  = (lp_q == link_rd) && (lp_q == ub_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (cmd_t'(command))
						CMD_INIT:  state_d = init_small ? ST_FIN : ST_I0;
						CMD_ALLOC: state_d = hp_q ? ST_A_TAG : ST_FIN;
						CMD_FREE:  state_d = (block_addr == '0) ? ST_FIN : ST_F_TAG;
						CMD_NOP:   state_d = ST_FIN;
						default:   state_d = ST_FIN;
					endcase
				end
			end
			ST_I0:    if (acc_done) state_d = ST_I1;
			ST_I1:    if (acc_done) state_d = ST_I2;
			ST_I2:    if (acc_done) state_d = ST_I3;
			ST_I3:    if (acc_done) state_d = ST_FIN;
			ST_A_TAG: if (acc_done) state_d = ST_A_CHK;
			ST_A_CHK: begin
				if (too_small)     state_d = ST_A_NEXT;
				else if (do_split) state_d = ST_A_S0;
				else               state_d = ST_U_TAG;
			end
			ST_A_NEXT:  if (acc_done) state_d = ST_A_TEST;
			ST_A_TEST:  state_d = walk_fail ? ST_FIN : ST_A_TAG;
			ST_A_S0:    if (acc_done) state_d = ST_A_S1;
			ST_A_S1:    if (acc_done) state_d = ST_A_S2;
			ST_A_S2:    if (acc_done) state_d = ST_A_S3;
			ST_A_S3:    if (acc_done) state_d = ST_FIN;
			ST_A_UDONE: state_d = ST_FIN;
			ST_U_TAG:   if (acc_done) state_d = ST_U_LP;
			ST_U_LP:    if (acc_done) state_d = ST_U_RP;
			ST_U_RP:    if (acc_done) state_d = unl_last ? ST_U_NT : ST_U_L1;
			ST_U_L1:    if (acc_done) state_d = ST_U_W1;
			ST_U_W1:    if (acc_done) state_d = ST_U_L2;
			ST_U_L2:    if (acc_done) state_d = ST_U_W2;
			ST_U_W2:    if (acc_done) state_d = ST_U_L3;
			ST_U_L3:    if (acc_done) state_d = ST_U_NT;
			ST_U_NT:    if (acc_done) state_d = ST_U_WR;
			ST_U_WR:    if (acc_done) state_d = ST_U_WB;
			ST_U_WB:    if (acc_done) state_d = uret_q;
			ST_J_RS:    if (acc_done) state_d = ST_J_LT;
			ST_J_LT:    if (acc_done) state_d = ST_J_W0;
			ST_J_W0:    if (acc_done) state_d = ST_J_W1;
			ST_J_W1:    if (acc_done) state_d = jret_q;
			ST_F_TAG:   if (acc_done) state_d = hp_q ? ST_F_R0 : ST_F_E0;
			ST_F_E0:    if (acc_done) state_d = ST_F_E1;
			ST_F_E1:    if (acc_done) state_d = ST_F_E2;
			ST_F_E2:    if (acc_done) state_d = ST_F_E3;
			ST_F_E3:    if (acc_done) state_d = ST_FIN;
			ST_F_R0:    if (acc_done) state_d = ST_F_R1;
			ST_F_R1:    if (acc_done) state_d = ST_F_W0;
			ST_F_W0:    if (acc_done) state_d = ST_F_R2;
			ST_F_R2:    if (acc_done) state_d = ST_F_W1;
			ST_F_W1:    if (acc_done) state_d = ST_F_W2;
			ST_F_W2:    if (acc_done) state_d = ST_F_W3;
			ST_F_W3:    if (acc_done) state_d = ST_F_T;
			ST_F_T:     if (acc_done) state_d = ST_F_W4;
			ST_F_W4:    if (acc_done) state_d = ST_F_W5;
			ST_F_W5:    if (acc_done) state_d = (fb_q != '0) ? ST_F_LT : ST_F_CUR;
			ST_F_LT:    if (acc_done) state_d = rd_pos ? ST_U_TAG : ST_F_CUR;
			ST_F_LM:    state_d = ST_F_CUR;
			ST_F_CUR:   if (acc_done) state_d = below_lim ? ST_F_NT : ST_FIN;
			ST_F_NT:    if (acc_done) state_d = rd_pos ? ST_U_TAG : ST_FIN;
			ST_FIN:     if (out_free) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// access requests and handshake outputs
	always_comb begin
		logic    access;
		acc_op_t op;
		aw_t     a;
		logic [TAG_W-1:0] d;
		access = 1'b1;
		op     = ACC_RD_TAG;
		a      = fb_q;
		d      = '0;
		unique case (state_q)
			ST_I0:     begin op = ACC_WR_TAG;  a = aw_t'(limit_q) - OFS_T; d = 32'(limit_q); end
			ST_I1:     begin op = ACC_WR_TAG;  a = '0;                     d = 32'(limit_q); end
			ST_I2:     begin op = ACC_WR_LINK; a = OFS_R; end
			ST_I3:     begin op = ACC_WR_LINK; a = OFS_L; end
			ST_A_TAG:  begin op = ACC_RD_TAG;  a = fh_q; end
			ST_A_NEXT: begin op = ACC_RD_LINK; a = fh_q + OFS_R; end
			ST_A_S0:   begin op = ACC_WR_TAG;  a = fh_q + aw_t'(t_q) - OFS_T; d = t_q; end
			ST_A_S1:   begin op = ACC_WR_TAG;  a = fh_q; d = t_q; end
			ST_A_S2:   begin op = ACC_WR_TAG;  a = fh_q + aw_t'(sz_q) - OFS_T; d = neg_busy; end
			ST_A_S3:   begin op = ACC_WR_TAG;  a = fh_q + aw_t'(t_q); d = neg_busy; end
			ST_U_TAG:  begin op = ACC_RD_TAG;  a = ub_q; end
			ST_U_LP:   begin op = ACC_RD_LINK; a = ub_q + OFS_L; end
			ST_U_RP:   begin op = ACC_RD_LINK; a = ub_q + OFS_R; end
			ST_U_L1:   begin op = ACC_RD_LINK; a = ub_q + OFS_L; end
			ST_U_W1:   begin op = ACC_WR_LINK; a = rp_q + OFS_L; d = 32'(aw_t'(t_q)); end
			ST_U_L2:   begin op = ACC_RD_LINK; a = ub_q + OFS_R; end
			ST_U_W2:   begin op = ACC_WR_LINK; a = lp_q + OFS_R; d = 32'(aw_t'(t_q)); end
			ST_U_L3:   begin op = ACC_RD_LINK; a = ub_q + OFS_R; end
			ST_U_NT:   begin op = ACC_RD_TAG;  a = ub_q; end
			ST_U_WR:   begin op = ACC_WR_TAG;  a = urtag_q; d = 32'd0 - t_q; end
			ST_U_WB:   begin op = ACC_WR_TAG;  a = ub_q; d = 32'd0 - t_q; end
			ST_J_RS:   begin op = ACC_RD_TAG;  a = ub_q; end
			ST_J_LT:   begin op = ACC_RD_TAG;  a = lb_q; end
			ST_J_W0:   begin op = ACC_WR_TAG;  a = ub_q - aw_t'(rsz_q) - OFS_T; d = nsz_q; end
			ST_J_W1:   begin op = ACC_WR_TAG;  a = lb_q; d = nsz_q; end
			ST_F_TAG:  begin op = ACC_RD_TAG;  a = fb_q; end
			ST_F_E0:   begin op = ACC_WR_TAG;  a = frtag_q; d = 32'd0 - sz_q; end
			ST_F_E1:   begin op = ACC_WR_TAG;  a = fb_q; d = 32'd0 - sz_q; end
			ST_F_E2:   begin op = ACC_WR_LINK; a = fb_q + OFS_R; d = 32'(fb_q); end
			ST_F_E3:   begin op = ACC_WR_LINK; a = fb_q + OFS_L; d = 32'(fb_q); end
			ST_F_R0:   begin op = ACC_RD_LINK; a = fh_q + OFS_R; end
			ST_F_R1:   begin op = ACC_RD_LINK; a = nextl_q; end
			ST_F_W0:   begin op = ACC_WR_LINK; a = fb_q + OFS_L; d = 32'(aw_t'(t_q)); end
			ST_F_R2:   begin op = ACC_RD_LINK; a = fh_q + OFS_R; end
			ST_F_W1:   begin op = ACC_WR_LINK; a = fb_q + OFS_R; d = 32'(aw_t'(t_q)); end
			ST_F_W2:   begin op = ACC_WR_LINK; a = nextl_q; d = 32'(fb_q); end
			ST_F_W3:   begin op = ACC_WR_LINK; a = fh_q + OFS_R; d = 32'(fb_q); end
			ST_F_T:    begin op = ACC_RD_TAG;  a = fb_q; end
			ST_F_W4:   begin op = ACC_WR_TAG;  a = frtag_q; d = 32'd0 - t_q; end
			ST_F_W5:   begin op = ACC_WR_TAG;  a = fb_q; d = 32'd0 - t_q; end
			ST_F_LT:   begin op = ACC_RD_TAG;  a = fb_q - OFS_T; end
			ST_F_CUR:  begin op = ACC_RD_TAG;  a = fb_q; end
			ST_F_NT:   begin op = ACC_RD_TAG;  a = fb_q + aw_t'(sz_q); end
			default:   access = 1'b0;
		endcase
		acc_req.valid = access && !issued_q;
		acc_req.op    = op;
		acc_addr      = a;
		acc_data      = d;
		in_ready      = (state_q == ST_IDLE);
		fin.valid     = (state_q == ST_FIN) && out_free;
		fin.status    = stat_q;
		result_addr   = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			issued_q <= 1'b0;
			hp_q     <= 1'b0;
			fh_q     <= '0;
			limit_q  <= '0;
		end else begin
			state_q <= state_d;
			if (acc_req.valid) begin
				issued_q <= 1'b1;
			end else if (acc_done) begin
				issued_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (cmd_t'(command) == CMD_INIT) begin
							limit_q <= init_n;
							fh_q    <= '0;
							hp_q    <= !init_small;
						end
					end
				end
				ST_A_NEXT:  if (acc_done) fh_q <= link_rd;
				ST_A_TEST:  if (walk_fail) fh_q <= start_q;
				ST_U_RP:    if (acc_done && unl_last) hp_q <= 1'b0;
				ST_U_L3:    if (acc_done) fh_q <= link_rd;
				ST_F_E3: begin
					if (acc_done) begin
						fh_q <= fb_q;
						hp_q <= 1'b1;
					end
				end
				ST_F_W5:    if (acc_done) fh_q <= fb_q;
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					res_q   <= '0;
					stat_q  <= (cmd_t'(command) == CMD_ALLOC) && !hp_q;
					size_q  <= (req_size < REQ_W'(MIN_REQ)) ? REQ_W'(MIN_REQ) : req_size;
					fb_q    <= aw_t'(block_addr) - OFS_T;
					start_q <= fh_q;
					steps_q <= '0;
				end
			end
			ST_A_TAG:  if (acc_done) sz_q <= acc_rdata;
			ST_A_CHK: begin
				t_q    <= rest;
				ub_q   <= fh_q;
				uret_q <= ST_A_UDONE;
			end
			ST_A_NEXT: if (acc_done) steps_q <= steps_q + lim_t'(1);
			ST_A_TEST: if (walk_fail) stat_q <= 1'b1;
			ST_A_S3:   if (acc_done) res_q <= PTR_W'(fh_q + aw_t'(t_q) + OFS_T);
			ST_A_UDONE: res_q <= PTR_W'(ub_q + OFS_T);
			ST_U_TAG:  if (acc_done) urtag_q <= ub_q + aw_t'(acc_rdata) - OFS_T;
			ST_U_LP:   if (acc_done) lp_q <= link_rd;
			ST_U_RP:   if (acc_done) rp_q <= link_rd;
			ST_U_L1, ST_U_L2, ST_U_NT: if (acc_done) t_q <= acc_rdata;
			ST_J_RS:   if (acc_done) rsz_q <= acc_rdata;
			ST_J_LT:   if (acc_done) nsz_q <= acc_rdata - rsz_q;
			ST_F_TAG: begin
				if (acc_done) begin
					sz_q    <= acc_rdata;
					frtag_q <= fb_q - aw_t'(acc_rdata) - OFS_T;
				end
			end
			ST_F_R0:   if (acc_done) nextl_q <= link_rd + OFS_L;
			ST_F_R1, ST_F_R2, ST_F_T: if (acc_done) t_q <= acc_rdata;
			ST_F_LT: begin
				// left neighbour free: merge it with this block
				if (acc_done && rd_pos) begin
					lb_q   <= fb_q - aw_t'(acc_rdata);
					ub_q   <= fb_q;
					uret_q <= ST_J_RS;
					jret_q <= ST_F_LM;
				end
			end
			ST_F_LM:   fb_q <= lb_q;
			ST_F_CUR:  if (acc_done) sz_q <= acc_rdata;
			ST_F_NT: begin
				if (acc_done && rd_pos) begin
					lb_q   <= fb_q;
					ub_q   <= fb_q + aw_t'(sz_q);
					uret_q <= ST_J_RS;
					jret_q <= ST_FIN;
				end
			end
			default: ;
		endcase
	end

endmodule

@@ bench/tb_boundary_tag_heap_allocator.sv @@
// Self-checking bench for boundary_tag_heap_allocator: directed and random
// init/allocate/free traffic, checked against a behavioral heap predictor.
// Depends on bta_pkg and the allocator top level.
`timescale 1ns / 1ps
module tb_boundary_tag_heap_allocator;
	import bta_pkg::*;

	localparam int HEAP = 4096;
	localparam int RAND_ITEMS = 1350;

	typedef struct {
		cmd_t        cmd;
		logic [12:0] req;
		logic [11:0] addr;
	} heap_cmd_t;

	typedef struct {
		logic [11:0] addr;
		logic        status;
	} heap_rsp_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [15:0] m_tdata;
	logic [0:0]  m_tuser;

	heap_cmd_t cmd_q[$];
	heap_rsp_t rsp_q[$];
	int        live[$];
	int        total_n, sent_n, recv_n, err_n;
	int        n_alloc, n_fail, n_free, n_init;

	// predictor state
	byte unsigned mem[HEAP];
	longint       fl_head;
	bit           fl_present;
	longint       heap_limit;

	boundary_tag_heap_allocator dut (.*);

	function automatic longint wa(longint x);
		longint r;
		r = x % HEAP;
		if (r < 0)
			r += HEAP;
		return r;
	endfunction

	function automatic longint get_tag(longint pos);
		bit [31:0] u;
		int        s;
		for (int i = 0; i < TAG_BYTES; i++)
			u[8*i +: 8] = mem[wa(pos + i)];
		s = u;
		return s;
	endfunction

	function automatic void put_tag(longint pos, longint v);
		bit [31:0] u;
		u = v[31:0];
		for (int i = 0; i < TAG_BYTES; i++)
			mem[wa(pos + i)] = u[8*i +: 8];
	endfunction

	function automatic longint get_link(longint pos);
		bit [63:0] u;
		for (int i = 0; i < LINK_BYTES; i++)
			u[8*i +: 8] = mem[wa(pos + i)];
		return u[11:0];
	endfunction

	function automatic void put_link(longint pos, longint v);
		bit [63:0] u;
		u = v;
		for (int i = 0; i < LINK_BYTES; i++)
			mem[wa(pos + i)] = u[8*i +: 8];
	endfunction

	function automatic longint take_block(longint b);
		longint sz, rt, lp, rp, v;
		sz = get_tag(b);
		rt = wa(b + sz - TAG_BYTES);
		lp = get_link(b + LEFT_OFS);
		rp = get_link(b + RIGHT_OFS);
		if (lp == rp && lp == b) begin
			fl_present = 0;
		end else begin
			put_link(rp + LEFT_OFS, get_link(b + LEFT_OFS));
			put_link(lp + RIGHT_OFS, get_link(b + RIGHT_OFS));
			fl_head = get_link(b + RIGHT_OFS);
		end
		v = -get_tag(b);
		put_tag(rt, v);
		put_tag(b, v);
		return wa(b + TAG_BYTES);
	endfunction

	function automatic longint heap_alloc(longint size, output bit fail);
		longint start, sz, h, rt, busy, rest;
		int     steps;
		fail = 0;
		steps = 0;
		if (size < MIN_REQ)
			size = MIN_REQ;
		if (!fl_present) begin
			fail = 1;
			return 0;
		end
		start = fl_head;
		sz = get_tag(fl_head);
		while (sz < 2 * TAG_BYTES + size) begin
			fl_head = get_link(fl_head + RIGHT_OFS);
			steps++;
			if (fl_head == start || steps > HEAP) begin
				fl_head = start;
				fail = 1;
				return 0;
			end
			sz = get_tag(fl_head);
		end
		if (sz > size + SPLIT_SLACK) begin
			h = fl_head;
			rt = wa(h + sz - TAG_BYTES);
			busy = size + 2 * TAG_BYTES;
			rest = sz - busy;
			put_tag(h + rest - TAG_BYTES, rest);
			put_tag(h, rest);
			put_tag(rt, -busy);
			put_tag(h + rest, -busy);
			return wa(h + rest + TAG_BYTES);
		end
		return take_block(fl_head);
	endfunction

	function automatic void merge_right(longint lb, longint rb);
		longint rsz, nsz, dummy;
		dummy = take_block(rb);
		rsz = get_tag(rb);
		nsz = get_tag(lb) - rsz;
		put_tag(rb - rsz - TAG_BYTES, nsz);
		put_tag(lb, nsz);
	endfunction

	function automatic void heap_free(longint p);
		longint b, sz, rt, v, prevr, nextl, cur, lsz, lb;
		if (p == 0)
			return;
		b = wa(p - TAG_BYTES);
		sz = get_tag(b);
		rt = wa(b - sz - TAG_BYTES);
		if (!fl_present) begin
			v = -sz;
			put_tag(rt, v);
			put_tag(b, v);
			put_link(b + RIGHT_OFS, b);
			put_link(b + LEFT_OFS, b);
			fl_head = b;
			fl_present = 1;
			return;
		end
		prevr = wa(fl_head + RIGHT_OFS);
		nextl = wa(get_link(prevr) + LEFT_OFS);
		put_link(b + LEFT_OFS, get_link(nextl));
		put_link(b + RIGHT_OFS, get_link(prevr));
		put_link(nextl, b);
		put_link(prevr, b);
		v = -get_tag(b);
		put_tag(rt, v);
		put_tag(b, v);
		fl_head = b;
		if (b > 0) begin
			lsz = get_tag(b - TAG_BYTES);
			if (lsz > 0) begin
				lb = wa(b - lsz);
				merge_right(lb, b);
				b = lb;
			end
		end
		cur = get_tag(b);
		if (b + cur < heap_limit && get_tag(b + cur) > 0)
			merge_right(b, wa(b + cur));
	endfunction

	// Runs one command through the predictor, queues it and its expected response.
	task automatic issue(cmd_t c, int req, int addr);
		heap_cmd_t it;
		heap_rsp_t r;
		longint    n;
		bit        fail;
		it.cmd = c;
		it.req = req[12:0];
		it.addr = addr[11:0];
		r.addr = '0;
		r.status = 0;
		case (c)
			CMD_INIT: begin
				n = it.req;
				if (n > HEAP)
					n = HEAP;
				heap_limit = n;
				live.delete();
				n_init++;
				if (n < MIN_REQ) begin
					fl_present = 0;
					fl_head = 0;
				end else begin
					put_tag(n - TAG_BYTES, n);
					put_tag(0, n);
					put_link(RIGHT_OFS, 0);
					put_link(LEFT_OFS, 0);
					fl_head = 0;
					fl_present = 1;
				end
			end
			CMD_ALLOC: begin
				n = heap_alloc(it.req, fail);
				r.addr = fail ? 12'd0 : n[11:0];
				r.status = fail;
				n_alloc++;
				if (fail)
					n_fail++;
				else
					live.push_back(int'(n));
			end
			CMD_FREE: begin
				heap_free(it.addr);
				n_free++;
			end
			default: ;
		endcase
		cmd_q.push_back(it);
		rsp_q.push_back(r);
	endtask

	task automatic free_live(int idx);
		int a;
		a = live[idx];
		live.delete(idx);
		issue(CMD_FREE, 0, a);
	endtask

	initial begin
		int k, r;
		fl_head = 0;
		fl_present = 0;
		heap_limit = 0;
		// directed
		issue(CMD_ALLOC, 40, 0);          // nothing initialized: fails
		issue(CMD_FREE, 0, 0);            // null free
		issue(CMD_NOP, 13'h1fff, 12'hfff);
		issue(CMD_INIT, 10, 0);           // too small for a block
		issue(CMD_ALLOC, 0, 0);
		issue(CMD_INIT, 64, 0);
		issue(CMD_ALLOC, 56, 0);          // takes the whole block, list empties
		free_live(0);                     // free into an empty list
		issue(CMD_INIT, 13'h1fff, 0);     // saturates at the arena size
		issue(CMD_ALLOC, 4096, 0);        // too big
		issue(CMD_ALLOC, 13'h1fff, 0);
		issue(CMD_ALLOC, 0, 0);
		issue(CMD_ALLOC, 100, 0);
		issue(CMD_ALLOC, 30, 0);
		issue(CMD_ALLOC, 2000, 0);
		free_live(1);                     // isolated free
		free_live(2);                     // merges with left neighbor
		free_live(0);                     // merges with its left neighbor
		issue(CMD_ALLOC, 4000, 0);
		issue(CMD_ALLOC, 1, 0);
		issue(CMD_NOP, 0, 0);
		while (live.size() > 0)
			free_live(0);
		issue(CMD_ALLOC, 4088, 0);
		// random traffic
		for (k = 0; k < RAND_ITEMS; k++) begin
			r = $urandom_range(0, 99);
			if (r < 2) begin
				if ($urandom_range(0, 3) == 0)
					issue(CMD_INIT, $urandom_range(0, 8191), 0);
				else
					issue(CMD_INIT, $urandom_range(1000, 4096), 0);
			end else if (r < 5) begin
				issue(CMD_NOP, $urandom_range(0, 8191), $urandom_range(0, 4095));
			end else if (r < 7) begin
				issue(CMD_FREE, $urandom_range(0, 8191), 0);
			end else if (r < 52 && live.size() > 0) begin
				free_live($urandom_range(0, live.size() - 1));
			end else if (r < 56) begin
				issue(CMD_ALLOC, $urandom_range(0, 8191), 0);
			end else begin
				issue(CMD_ALLOC, $urandom_range(0, 200), 0);
			end
		end
		total_n = cmd_q.size();
	end

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
	end

	// phase 0 no idling, 1 sender idles, 2 receiver stalls, 3 both
	function automatic bit hold(int done, bit sender);
		int ph;
		ph = (total_n == 0) ? 0 : done * 4 / total_n;
		if (ph == 0)
			return 0;
		if (ph == 3)
			return $urandom_range(0, 99) < 32;
		if ((ph == 1) == sender)
			return $urandom_range(0, 99) < 83;
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
		end else begin
			if (s_tvalid && s_tready)
				sent_n++;
			if (!s_tvalid || s_tready) begin
				if (cmd_q.size() > 0 && !hold(sent_n, 1)) begin
					s_tvalid <= 1;
					s_tdata <= {7'd0, cmd_q[0].addr, cmd_q[0].req};
					s_tuser <= cmd_q[0].cmd;
					void'(cmd_q.pop_front());
				end else begin
					s_tvalid <= 0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		heap_rsp_t e;
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			m_tready <= !hold(recv_n, 0);
			if (m_tvalid && m_tready) begin
				recv_n++;
				if (rsp_q.size() == 0) begin
					err_n++;
					$display("%0t: response with none pending: addr %0d status %0d",
						$time, m_tdata[11:0], m_tuser[0]);
				end else begin
					e = rsp_q.pop_front();
					if (m_tdata[11:0] !== e.addr) begin
						err_n++;
						$display("%0t: result_addr expected %0d actual %0d",
							$time, e.addr, m_tdata[11:0]);
					end
					if (m_tuser[0] !== e.status) begin
						err_n++;
						$display("%0t: status expected %0d actual %0d",
							$time, e.status, m_tuser[0]);
					end
				end
			end
		end
	end

	initial begin
		wait (arst_n && total_n > 0);
		wait (cmd_q.size() == 0 && !s_tvalid && rsp_q.size() == 0);
		repeat (400) @(posedge clk);
		$display("Ran %0d commands: %0d allocates (%0d failed), %0d frees, %0d inits.",
			total_n, n_alloc, n_fail, n_free, n_init);
		if (err_n == 0 && rsp_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#100ms;
		$display("Timed out with %0d responses outstanding.", rsp_q.size());
		$display("TB_ERROR");
		$finish;
	end

endmodule
